@@ hdl/bale_pkg.sv @@
// Package for the bounded array list engine: word types, opcodes, status codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package bale_pkg;

  localparam int MaxEntries = 1024;
  localparam int AddrW      = 10;
  localparam int CntW       = 11;
  localparam int ValW       = 32;

  localparam logic [CntW-1:0] NoneIndex = '1;

  typedef enum logic [2:0] {
    OP_APPEND     = 3'd0,
    OP_REMOVE_AT  = 3'd1,
    OP_REMOVE_VAL = 3'd2,
    OP_FIND       = 3'd3,
    OP_CLEAR      = 3'd4,
    OP_READ       = 3'd5
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BADPOS   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SHIFT,
    S_READ,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]             opcode;
    logic signed [ValW-1:0] value;
    logic [AddrW-1:0]       position;
  } in_word_t;

  typedef struct packed {
    logic signed [CntW-1:0] found_index;
    logic signed [ValW-1:0] read_data;
    logic [CntW-1:0]        element_count;
    logic [1:0]             status;
  } out_word_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic scan;
    logic shift;
    logic read;
    logic load;
  } ctl_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       pos_ok;
    logic       scan_hit;
    logic       scan_miss;
    logic       shift_done;
    logic       out_free;
  } dp_sts_t;

endpackage

@@ hdl/bale_ctrl.sv @@
// Controller state machine of the array list engine.
// Depends on bale_pkg; drives the datapath through ctl_cmd_t and reads dp_sts_t.
module bale_ctrl
  import bale_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_sts_t  sts_i,
  output ctl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        unique case (sts_i.op) inside
          OP_REMOVE_AT:            state_d = sts_i.pos_ok ? S_SHIFT : S_DONE;
          OP_REMOVE_VAL, OP_FIND:  state_d = S_SCAN;
          OP_READ:                 state_d = sts_i.pos_ok ? S_READ : S_DONE;
          default:                 state_d = S_DONE;
        endcase
      end
      S_SCAN: begin
        if (sts_i.scan_hit) begin
          state_d = (sts_i.op == OP_REMOVE_VAL) ? S_SHIFT : S_DONE;
        end else if (sts_i.scan_miss) begin
          state_d = S_DONE;
        end
      end
      S_SHIFT: begin
        if (sts_i.shift_done) state_d = S_DONE;
      end
      S_READ: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.accept  = in_valid_i;
      end
      S_EXEC:  cmd_o.exec  = 1'b1;
      S_SCAN:  cmd_o.scan  = 1'b1;
      S_SHIFT: cmd_o.shift = 1'b1;
      S_READ:  cmd_o.read  = 1'b1;
      S_DONE:  cmd_o.load  = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

@@ hdl/bale_dp.sv @@
// Datapath of the array list engine: element memory, count, scan and shift pointers,
// and the output word register. Depends on bale_pkg; commanded by bale_ctrl.
module bale_dp
  import bale_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  in_word_i,
  input  ctl_cmd_t  cmd_i,
  output dp_sts_t   sts_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  logic [ValW-1:0] mem [MaxEntries];
  logic [ValW-1:0] rdata_q;

  logic [2:0]             op_q, op_d;
  logic [ValW-1:0]        val_q, val_d;
  logic [AddrW-1:0]       pos_q, pos_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [CntW-1:0]        ptr_q, ptr_d;
  logic [AddrW-1:0]       wptr_q, wptr_d;
  logic [AddrW-1:0]       rd_idx_q, rd_idx_d;
  logic                   rd_vld_q, rd_vld_d;
  logic [CntW-1:0]        found_q, found_d;
  logic [1:0]             status_q, status_d;
  logic                   out_valid_q;
  out_word_t              out_q;

  logic                   we, re;
  logic [AddrW-1:0]       waddr;
  logic [ValW-1:0]        wdata;
  logic                   issue, full, pos_ok, match, walk_end, out_free;

  assign issue    = ptr_q < count_q;
  assign full     = count_q >= CntW'(MaxEntries);
  assign pos_ok   = {1'b0, pos_q} < count_q;
  assign match    = rd_vld_q && (rdata_q == val_q);
  // Nothing left to issue and nothing in flight from the memory.
  assign walk_end = !rd_vld_q && !issue;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    op_d     = op_q;
    val_d    = val_q;
    pos_d    = pos_q;
    count_d  = count_q;
    ptr_d    = ptr_q;
    wptr_d   = wptr_q;
    rd_idx_d = rd_idx_q;
    rd_vld_d = rd_vld_q;
    found_d  = found_q;
    status_d = status_q;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = count_q[AddrW-1:0];
    wdata    = val_q;

    if (cmd_i.accept) begin
      op_d     = in_word_i.opcode;
      val_d    = in_word_i.value;
      pos_d    = in_word_i.position;
      found_d  = NoneIndex;
      status_d = ST_OK;
      rd_vld_d = 1'b0;
    end

    if (cmd_i.exec) begin
      unique case (op_q) inside
        OP_APPEND: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            we      = 1'b1;
            count_d = count_q + CntW'(1);
          end
        end
        OP_REMOVE_AT: begin
          if (pos_ok) begin
            ptr_d  = {1'b0, pos_q} + CntW'(1);
            wptr_d = pos_q;
          end else begin
            status_d = ST_BADPOS;
          end
        end
        OP_REMOVE_VAL, OP_FIND: begin
          ptr_d = '0;
        end
        OP_CLEAR: begin
          count_d = '0;
        end
        OP_READ: begin
          if (pos_ok) begin
            ptr_d = {1'b0, pos_q};
          end else begin
            status_d = ST_BADPOS;
          end
        end
        default: ;
      endcase
    end

    // The scan compares one entry per cycle, in the cycle after the read it issued.
    if (cmd_i.scan) begin
      re       = issue;
      rd_vld_d = issue;
      rd_idx_d = ptr_q[AddrW-1:0];
      if (issue) ptr_d = ptr_q + CntW'(1);
      if (match) begin
        found_d  = {1'b0, rd_idx_q};
        ptr_d    = {1'b0, rd_idx_q} + CntW'(1);
        wptr_d   = rd_idx_q;
        rd_vld_d = 1'b0;
      end else if (walk_end) begin
        status_d = ST_NOTFOUND;
      end
    end

    // Each entry read here is written one place lower on the next cycle.
    if (cmd_i.shift) begin
      re       = issue;
      rd_vld_d = issue;
      rd_idx_d = ptr_q[AddrW-1:0];
      if (issue) ptr_d = ptr_q + CntW'(1);
      if (rd_vld_q) begin
        we     = 1'b1;
        waddr  = wptr_q;
        wdata  = rdata_q;
        wptr_d = wptr_q + AddrW'(1);
      end
      if (walk_end) count_d = count_q - CntW'(1);
    end

    if (cmd_i.read) re = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[ptr_q[AddrW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      rd_vld_q <= rd_vld_d;
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    val_q    <= val_d;
    pos_q    <= pos_d;
    ptr_q    <= ptr_d;
    wptr_q   <= wptr_d;
    rd_idx_q <= rd_idx_d;
    found_q  <= found_d;
    status_q <= status_d;
    if (cmd_i.load) begin
      out_q.found_index   <= found_q;
      out_q.read_data     <= (op_q == OP_READ && status_q == ST_OK) ? rdata_q : '0;
      out_q.element_count <= count_q;
      out_q.status        <= status_q;
    end
  end

  assign sts_o.op         = op_q;
  assign sts_o.pos_ok     = pos_ok;
  assign sts_o.scan_hit   = match;
  assign sts_o.scan_miss  = walk_end;
  assign sts_o.shift_done = walk_end;
  assign sts_o.out_free   = out_free;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxEntries))
    else $error("element count above capacity");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.exec || cmd_i.shift) |=> $stable(count_q))
    else $error("element count changed outside execute or shift");

  a_shift_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.shift && rd_vld_q) |-> ((wptr_q + AddrW'(1)) == rd_idx_q))
    else $error("shift write pointer not one below the entry read");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (!out_valid_q || out_ready_i))
    else $error("output word overwritten before it was taken");
`endif

endmodule

@@ hdl/bounded_array_list_engine.sv @@
// Top level of the bounded array list engine: controller plus datapath.
// Depends on bale_pkg, bale_ctrl and bale_dp.
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+-----------------------------
//   input   | in        | in_valid_i/in_ready_o  | in_word_i  (opcode, value, position)
//   output  | out       | out_valid_o/out_ready_i| out_word_o (found_index, read_data,
//           |           |                        |             element_count, status)
//
// One word is worked on at a time; the memory port sets the pace at one entry per cycle.
// Append, clear, unused opcodes and rejected positions end after execute, read-at after
// a memory read. Find stops at the first hit; remove-by-value shifts the entries past it
// down; both scan all entries on a miss. Remove-at shifts down those past the position.
// Reset clears the count and valid flags; the memory is not cleared and needs no pass.
// A result waiting in the output register does not stop the next word from being taken.
module bounded_array_list_engine
  import bale_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  bale_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bale_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

@@ test/bale_list_checker.sv @@
// Checker for the bounded array list engine: watches both word channels, keeps its own
// copy of the list, predicts every result word and compares it field by field.
// Depends on bale_pkg.
module bale_list_checker
  import bale_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_word_t  in_word_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_word_t out_word_i,
  output int        fail_count_o,
  output int        pending_o,
  output int        checked_o
);

  logic [ValW-1:0] list_mem [MaxEntries];
  int              list_len = 0;
  out_word_t       awaited_results [$];
  out_word_t       want_word;
  int              fails = 0;
  int              checked = 0;

  // Drops one entry and closes the gap, the same walk as the block's shift-down.
  function automatic void drop_entry(input int at);
    for (int i = at; i < list_len - 1; i++) list_mem[i] = list_mem[i + 1];
    list_len--;
  endfunction

  function automatic out_word_t apply_list_op(input in_word_t w);
    out_word_t r;
    int        hit_at;
    r.found_index   = NoneIndex;
    r.read_data     = '0;
    r.status        = ST_OK;
    hit_at          = -1;
    if (w.opcode == OP_REMOVE_VAL || w.opcode == OP_FIND) begin
      // Walk downward so the lowest matching index is the one left standing.
      for (int i = list_len - 1; i >= 0; i--) begin
        if (list_mem[i] == w.value) hit_at = i;
      end
    end
    case (w.opcode)
      OP_APPEND: begin
        if (list_len >= MaxEntries) begin
          r.status = ST_FULL;
        end else begin
          list_mem[list_len] = w.value;
          list_len++;
        end
      end
      OP_REMOVE_AT: begin
        if (int'(w.position) >= list_len) r.status = ST_BADPOS;
        else drop_entry(int'(w.position));
      end
      OP_REMOVE_VAL: begin
        if (hit_at < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.found_index = CntW'(hit_at);
          drop_entry(hit_at);
        end
      end
      OP_FIND: begin
        if (hit_at < 0) r.status = ST_NOTFOUND;
        else r.found_index = CntW'(hit_at);
      end
      OP_CLEAR: begin
        list_len = 0;
      end
      OP_READ: begin
        if (int'(w.position) >= list_len) r.status = ST_BADPOS;
        else r.read_data = list_mem[w.position];
      end
      default: begin
      end
    endcase
    r.element_count = CntW'(list_len);
    return r;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      fails++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaited_results.delete();
      list_len     = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
      checked_o    <= 0;
    end else begin
      // A result can never belong to a word taken at the same edge, so pop before push.
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          fails++;
          $display("%0t: result word with nothing expected, expected none, actual %h",
                   $time, out_word_i);
        end else begin
          want_word = awaited_results.pop_front();
          check_field("found_index", $signed(want_word.found_index),
                      $signed(out_word_i.found_index));
          check_field("read_data", $signed(want_word.read_data),
                      $signed(out_word_i.read_data));
          check_field("element_count", want_word.element_count, out_word_i.element_count);
          check_field("status", want_word.status, out_word_i.status);
          checked++;
        end
      end
      if (in_valid_i && in_ready_i) awaited_results.push_back(apply_list_op(in_word_i));
      pending_o    <= awaited_results.size();
      fail_count_o <= fails;
      checked_o    <= checked;
    end
  end

endmodule

@@ test/tb_bounded_array_list_engine.sv @@
// Testbench top for the bounded array list engine: clock, reset, word stimulus with
// bursty sending and a stalling receiver, and the verdict.
// Depends on bale_pkg, bounded_array_list_engine and bale_list_checker.
module tb_bounded_array_list_engine;
  import bale_pkg::*;

  localparam logic [2:0] OpUnused6   = 3'd6;
  localparam logic [2:0] OpUnused7   = 3'd7;
  localparam int         RandomWords = 580;
  localparam int         PoolSize    = 12;
  localparam int         DrainCycles = 2100;
  localparam int         CycleLimit  = 10_000_000;

  typedef enum logic [1:0] {
    RDY_OPEN,
    RDY_COIN,
    RDY_SPARSE,
    RDY_BURSTY
  } stall_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_word;

  int          fail_count;
  int          pending;
  int          checked;
  int          words_sent = 0;
  int          burst_left = 0;
  int          cycle_count = 0;
  stall_mode_e rdy_mode = RDY_OPEN;
  int          rdy_tick = 0;
  logic [ValW-1:0] value_pool [PoolSize];

  bounded_array_list_engine uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  bale_list_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_word_i   (out_word),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // The receiver picks a new stall mode at random each time its mode timer runs out.
  always @(negedge clk_i) begin
    if (rdy_tick == 0) begin
      rdy_mode = stall_mode_e'($urandom_range(0, 3));
      rdy_tick = $urandom_range(16, 96);
    end
    rdy_tick--;
    case (rdy_mode)
      RDY_OPEN:   out_ready = 1'b1;
      RDY_COIN:   out_ready = 1'($urandom_range(0, 1));
      RDY_SPARSE: out_ready = ($urandom_range(0, 3) == 0);
      default:    out_ready = (rdy_tick % 8 == 0);
    endcase
  end

  function automatic in_word_t pack_word(input logic [2:0] op, input logic [ValW-1:0] val,
                                         input logic [AddrW-1:0] pos);
    in_word_t w;
    w.opcode   = op;
    w.value    = val;
    w.position = pos;
    return w;
  endfunction

  // Sends one word; valid stays high across a burst and drops only for a gap.
  task automatic issue_word(input in_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_word  = w;
    in_valid = 1'b1;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
    burst_left--;
    words_sent++;
  endtask

  task automatic wait_for_results();
    in_valid   = 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic logic [ValW-1:0] pick_value();
    if ($urandom_range(0, 9) < 7) return value_pool[$urandom_range(0, PoolSize - 1)];
    return $urandom;
  endfunction

  function automatic in_word_t make_random_word();
    int         pick;
    logic [2:0] op;
    pick = $urandom_range(0, 99);
    if (pick < 34)      op = OP_APPEND;
    else if (pick < 46) op = OP_REMOVE_AT;
    else if (pick < 60) op = OP_REMOVE_VAL;
    else if (pick < 78) op = OP_FIND;
    else if (pick < 92) op = OP_READ;
    else if (pick < 95) op = OP_CLEAR;
    else                op = $urandom_range(0, 1) ? OpUnused6 : OpUnused7;
    // Mostly short positions so that reads and removals land inside the list.
    return pack_word(op, pick_value(),
                     ($urandom_range(0, 9) < 7) ? AddrW'($urandom_range(0, 47))
                                                : AddrW'($urandom_range(0, 1023)));
  endfunction

  initial begin
    value_pool[0] = 32'h7fff_ffff;
    value_pool[1] = 32'h8000_0000;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < PoolSize; i++) value_pool[i] = $urandom;

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Empty list: every lookup must miss or reject its position, then appends and finds.
    issue_word(pack_word(OP_READ, 32'd0, 10'd0));
    issue_word(pack_word(OP_REMOVE_AT, 32'd0, 10'd0));
    issue_word(pack_word(OP_FIND, 32'd0, 10'd0));
    issue_word(pack_word(OP_REMOVE_VAL, 32'hffff_ffff, 10'd0));
    issue_word(pack_word(OpUnused6, 32'h8000_0000, 10'd1023));
    issue_word(pack_word(OP_APPEND, 32'h7fff_ffff, 10'd1023));
    issue_word(pack_word(OP_APPEND, 32'h8000_0000, 10'd0));
    issue_word(pack_word(OP_APPEND, 32'd0, 10'd0));
    issue_word(pack_word(OP_APPEND, 32'hffff_ffff, 10'd0));
    issue_word(pack_word(OP_APPEND, 32'd0, 10'd0));
    issue_word(pack_word(OP_FIND, 32'hffff_ffff, 10'd0));
    issue_word(pack_word(OP_FIND, 32'h8000_0000, 10'd0));
    // The duplicate zero checks that only the first match goes.
    issue_word(pack_word(OP_REMOVE_VAL, 32'd0, 10'd0));
    issue_word(pack_word(OP_READ, 32'd0, 10'd3));
    issue_word(pack_word(OP_READ, 32'd0, 10'd4));
    issue_word(pack_word(OP_REMOVE_AT, 32'd0, 10'd0));
    issue_word(pack_word(OP_REMOVE_AT, 32'd0, 10'd2));
    issue_word(pack_word(OP_READ, 32'd0, 10'd1));
    issue_word(pack_word(OP_FIND, 32'h1234_5678, 10'd0));
    issue_word(pack_word(OP_CLEAR, 32'h7fff_ffff, 10'd1023));
    issue_word(pack_word(OP_READ, 32'd0, 10'd0));
    issue_word(pack_word(OP_READ, 32'd0, 10'd1023));
    issue_word(pack_word(OpUnused7, 32'hffff_ffff, 10'd1023));
    wait_for_results();

    // Fill to capacity, push past it, then work at the far end and across the whole store.
    for (int i = 0; i < MaxEntries + 2; i++) issue_word(pack_word(OP_APPEND, pick_value(), 10'd0));
    issue_word(pack_word(OP_READ, 32'd0, 10'd1023));
    issue_word(pack_word(OP_FIND, value_pool[5], 10'd0));
    issue_word(pack_word(OP_REMOVE_AT, 32'd0, 10'd0));
    issue_word(pack_word(OP_APPEND, 32'h8000_0000, 10'd0));
    issue_word(pack_word(OP_APPEND, 32'h7fff_ffff, 10'd0));
    issue_word(pack_word(OP_REMOVE_AT, 32'd0, 10'd1023));
    issue_word(pack_word(OP_READ, 32'd0, 10'd1023));
    issue_word(pack_word(OP_REMOVE_VAL, value_pool[3], 10'd0));
    issue_word(pack_word(OP_CLEAR, 32'd0, 10'd0));

    for (int i = 0; i < RandomWords; i++) begin
      if (i == RandomWords / 2) wait_for_results();
      issue_word(make_random_word());
    end

    wait_for_results();
    repeat (DrainCycles) @(negedge clk_i);

    $display("Run covered %0d words: empty-list and edge cases, a fill past all %0d entries,",
             words_sent, MaxEntries);
    $display("and %0d random operations; %0d result words were compared.", RandomWords, checked);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/bale_pkg.sv
hdl/bale_ctrl.sv
hdl/bale_dp.sv
hdl/bounded_array_list_engine.sv
test/bale_list_checker.sv
test/tb_bounded_array_list_engine.sv
